// ===== hdl/dual_float32_multiplier_unit_assert.svh =====
// Assertion macros shared by the dual float32 multiplier RTL.
`ifndef DUAL_FLOAT32_MULTIPLIER_UNIT_ASSERT_SVH
`define DUAL_FLOAT32_MULTIPLIER_UNIT_ASSERT_SVH
// Same-cycle implication, checked on clk and disabled during rst.
`define DFM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, checked on clk and disabled during rst.
`define DFM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`endif

// ===== hdl/dfm_pkg.sv =====
// Package: request/response types, stage types and binary32 constants.
`timescale 1ns / 1ps
package dfm_pkg;

  localparam logic [31:0] QNAN_BITS = 32'h7FC0_0000;
  localparam logic [31:0] INF_BITS  = 32'h7F80_0000;

  localparam logic REQ_WRITE = 1'b0;
  localparam logic REQ_READ  = 1'b1;

  typedef struct packed {
    logic        req_type;
    logic [31:0] operand_a;
    logic [31:0] operand_b;
    logic [31:0] operand_c;
    logic [31:0] operand_d;
  } dfm_req_t;

  typedef struct packed {
    logic [31:0] product_one;
    logic [31:0] product_two;
  } dfm_rsp_t;

  typedef struct packed {
    logic              special;
    logic [31:0]       special_bits;
    logic              sign;
    logic signed [9:0] exp;
    logic [23:0]       mant_a;
    logic [23:0]       mant_b;
  } dfm_unp_t;

  typedef struct packed {
    logic              special;
    logic [31:0]       special_bits;
    logic              sign;
    logic signed [9:0] exp;
    logic [47:0]       prod;
  } dfm_prd_t;

endpackage

// ===== hdl/dfm_unpack.sv =====
// Operand unpack: classify specials, normalize subnormals, sum exponents.
`timescale 1ns / 1ps
module dfm_unpack import dfm_pkg::*; (
  input  logic [31:0] a,
  input  logic [31:0] b,
  output dfm_unp_t    unp
);

  logic [7:0]  ea, eb;
  logic [22:0] ma, mb;
  logic        za, zb, na, nb, ia, ib;
  logic [4:0]  sha, shb;
  logic signed [9:0] ean, ebn;
  logic [23:0] man, mbn;

  always_comb begin
    ea = a[30:23];
    eb = b[30:23];
    ma = a[22:0];
    mb = b[22:0];
    za = (ea == 8'h00) && (ma == 23'd0);
    zb = (eb == 8'h00) && (mb == 23'd0);
    na = (ea == 8'hFF) && (ma != 23'd0);
    nb = (eb == 8'hFF) && (mb != 23'd0);
    ia = (ea == 8'hFF) && (ma == 23'd0);
    ib = (eb == 8'hFF) && (mb == 23'd0);
    // leading one position of a subnormal fraction
    sha = 5'd0;
    shb = 5'd0;
    for (int i = 0; i < 23; i++) begin
      if (ma[i]) sha = 5'(23 - i);
      if (mb[i]) shb = 5'(23 - i);
    end
    if (ea == 8'h00) begin
      ean = 10'sd1 - $signed({5'b0, sha});
      man = {1'b0, ma} << sha;
    end else begin
      ean = $signed({2'b0, ea});
      man = {1'b1, ma};
    end
    if (eb == 8'h00) begin
      ebn = 10'sd1 - $signed({5'b0, shb});
      mbn = {1'b0, mb} << shb;
    end else begin
      ebn = $signed({2'b0, eb});
      mbn = {1'b1, mb};
    end
    unp.sign   = a[31] ^ b[31];
    unp.exp    = ean + ebn - 10'sd126;
    unp.mant_a = man;
    unp.mant_b = mbn;
    unp.special      = na || nb || ia || ib || za || zb;
    unp.special_bits = {unp.sign, 31'd0};
    if (na || nb || ((ia || ib) && (za || zb))) begin
      unp.special_bits = QNAN_BITS;
    end else if (ia || ib) begin
      unp.special_bits = {unp.sign, INF_BITS[30:0]};
    end
  end

endmodule

// ===== hdl/dfm_round.sv =====
// Product normalize, underflow shift and round-to-nearest-even.
`timescale 1ns / 1ps
module dfm_round import dfm_pkg::*; (
  input  dfm_prd_t    prd,
  output logic [31:0] result
);

  logic [47:0]       p, q, mask;
  logic signed [9:0] e;
  logic [8:0]        sh;
  logic [23:0]       mant, rem;
  logic              inc;
  logic [24:0]       mant_r;
  logic [7:0]        ef;
  logic [31:0]       bits;

  always_comb begin
    p = prd.prod;
    e = prd.exp;
    if (!p[47]) begin
      p = p << 1;
      e = e - 10'sd1;
    end
    sh   = 9'((10'sd1 - e) & 10'h1FF);
    mask = '0;
    q    = p;
    if (e <= 10'sd0) begin
      if (sh >= 9'd48) begin
        q = {47'd0, |p};
      end else begin
        mask = ~({48{1'b1}} << sh[5:0]);
        q    = (p >> sh[5:0]) | {47'd0, |(p & mask)};
      end
    end
    mant   = q[47:24];
    rem    = q[23:0];
    inc    = (rem > 24'h80_0000) || ((rem == 24'h80_0000) && mant[0]);
    mant_r = {1'b0, mant} + {24'd0, inc};
    ef     = (e <= 10'sd0) ? 8'd0 : (e[7:0] - 8'd1);
    bits   = ({24'd0, ef} << 23) + {7'd0, mant_r};
    if (prd.special) begin
      result = prd.special_bits;
    end else if ((e >= 10'sd255) || (bits >= INF_BITS)) begin
      result = {prd.sign, INF_BITS[30:0]};
    end else begin
      result = {prd.sign, bits[30:0]};
    end
  end

endmodule

// ===== hdl/dual_float32_multiplier_unit.sv =====
// Top level: dual binary32 multiplier with stored products, four-stage pipeline.
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | dfm_req_t (req_type, operand_a..d)
//  rsp     | out       | rsp_valid/rsp_ready  | dfm_rsp_t (product_one, product_two)
//
// Each request passes from acceptance to response through the input register,
// unpack register, 24x24 product register, then round into the response register.
// One request per cycle is sustained while rsp_ready is high; every stage holds
// only while the stage after it is full and stalled, so bubbles drain even
// when rsp_ready is low. Requests stay in order, so a read always sees every
// earlier write. rst clears the stage valid bits and both stored products.
`timescale 1ns / 1ps
`include "dual_float32_multiplier_unit_assert.svh"
module dual_float32_multiplier_unit import dfm_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     req_valid,
  output logic     req_ready,
  input  dfm_req_t req,
  output logic     rsp_valid,
  input  logic     rsp_ready,
  output dfm_rsp_t rsp
);

  // Stage valids and readies
  logic v1, v2, v3;
  logic r1, r2, r3, ro;

  // Stage payloads
  dfm_req_t    s1;
  logic        s2_type, s3_type;
  dfm_unp_t    s2_one, s2_two;
  dfm_prd_t    s3_one, s3_two;
  dfm_unp_t    unp_one, unp_two;
  logic [31:0] res_one, res_two;
  logic [31:0] stored_one, stored_two;
  logic        wr_commit;

  assign ro        = !rsp_valid || rsp_ready;
  assign r3        = !v3 || ro;
  assign r2        = !v2 || r3;
  assign r1        = !v1 || r2;
  assign req_ready = r1;
  assign wr_commit = v3 && ro && (s3_type == REQ_WRITE);

  dfm_unpack u_unp_one (.a(s1.operand_a), .b(s1.operand_b), .unp(unp_one));
  dfm_unpack u_unp_two (.a(s1.operand_c), .b(s1.operand_d), .unp(unp_two));
  dfm_round  u_rnd_one (.prd(s3_one), .result(res_one));
  dfm_round  u_rnd_two (.prd(s3_two), .result(res_two));

  // Advance valids
  always_ff @(posedge clk) begin
    if (rst) begin
      v1         <= 1'b0;
      v2         <= 1'b0;
      v3         <= 1'b0;
      rsp_valid  <= 1'b0;
      stored_one <= '0;
      stored_two <= '0;
    end else begin
      if (r1) v1 <= req_valid;
      if (r2) v2 <= v1;
      if (r3) v3 <= v2;
      if (ro) rsp_valid <= v3;
      // Commit products of a write as it leaves the last stage
      if (wr_commit) begin
        stored_one <= res_one;
        stored_two <= res_two;
      end
    end
  end

  // Payload registers: load when the stage takes a request
  always_ff @(posedge clk) begin
    if (r1 && req_valid) s1 <= req;
    if (r2 && v1) begin
      s2_type <= s1.req_type;
      s2_one  <= unp_one;
      s2_two  <= unp_two;
    end
    if (r3 && v2) begin
      s3_type <= s2_type;
      s3_one  <= '{special: s2_one.special, special_bits: s2_one.special_bits,
                   sign: s2_one.sign, exp: s2_one.exp,
                   prod: s2_one.mant_a * s2_one.mant_b};
      s3_two  <= '{special: s2_two.special, special_bits: s2_two.special_bits,
                   sign: s2_two.sign, exp: s2_two.exp,
                   prod: s2_two.mant_a * s2_two.mant_b};
    end
    if (ro && v3) begin
      if (s3_type == REQ_WRITE) begin
        rsp <= '0;
      end else begin
        rsp <= '{product_one: stored_one, product_two: stored_two};
      end
    end
  end

  `DFM_ASSERT_NEXT(a_stored_hold, !wr_commit, $stable(stored_one) && $stable(stored_two), "stored product changed without a write")
  `DFM_ASSERT_NOW(a_stall_full, v2 && !r2, v3 && rsp_valid, "stage held while downstream not full")
  `DFM_ASSERT_NEXT(a_nan_canon, wr_commit, stored_one[30:23] != 8'hFF || stored_one[22:0] == 23'd0 || stored_one == QNAN_BITS, "non-canonical NaN stored")
  `DFM_ASSERT_NEXT(a_write_zero, ro && v3 && (s3_type == REQ_WRITE), rsp == '0, "write response not zero")

endmodule
